### rtl/core/bpdc_pkg.sv
`default_nettype none

package bpdc_pkg;

	// Field widths
	localparam int PIN_W   = 6;
	localparam int STAMP_W = 63;
	localparam int CODE_W  = 2;
	localparam int LIMIT_W = 32;
	localparam int HELD_W  = STAMP_W + 1;

	// Stream and configuration port widths
	localparam int S_TDATA_W = 72;
	localparam int M_TDATA_W = 72;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;

	// Button slots that have a pin register
	localparam int SLOT_REGS = 4;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_LIMIT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_LIMIT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT0_PIN   = 3'd2;

	// Reset values of the limits, in microseconds
	localparam logic [LIMIT_W-1:0] SHORT_LIMIT_RST = 32'd500000;
	localparam logic [LIMIT_W-1:0] LONG_LIMIT_RST  = 32'd4000000;

	// Event codes
	typedef enum logic [CODE_W-1:0] {
		EV_PRESSED       = 2'd0,
		EV_RELEASED      = 2'd1,
		EV_LONG_RELEASED = 2'd2,
		EV_VLONG_RELEASED = 2'd3
	} event_code_t;

	// Request from the top level to the slot bank
	typedef struct packed {
		logic               strobe;
		logic [PIN_W-1:0]   pin;
		logic               down;
		logic [STAMP_W-1:0] stamp;
	} slot_req_t;

	// Answer of the slot bank for the lowest matching slot
	typedef struct packed {
		logic               hit;
		logic               held;
		logic               changed;
		logic [STAMP_W-1:0] edge_time;
	} slot_look_t;

endpackage

`default_nettype wire

### rtl/core/bpdc_slots.sv
`default_nettype none

module bpdc_slots #(
	parameter int NUM_BUTTONS = 4
) (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	input  wire logic [NUM_BUTTONS-1:0][bpdc_pkg::PIN_W-1:0] slot_pins,
	input  wire bpdc_pkg::slot_req_t                        req,
	output bpdc_pkg::slot_look_t                            look
);
	import bpdc_pkg::*;

	logic [NUM_BUTTONS-1:0] match;
	logic [NUM_BUTTONS-1:0] held_q;
	logic [STAMP_W-1:0]     edge_q [NUM_BUTTONS];
	logic                   wr;

	// A slot whose pin is zero is unused and never matches.
	always_comb begin
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			match[i] = (slot_pins[i] != '0) && (slot_pins[i] == req.pin);
		end
	end

	// The lowest matching slot supplies the held flag and the recorded time.
	always_comb begin
		look.hit       = |match;
		look.held      = 1'b0;
		look.edge_time = '0;
		for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
			if (match[i]) begin
				look.held      = held_q[i];
				look.edge_time = edge_q[i];
			end
		end
		look.changed = look.hit && (req.down != look.held);
	end

	assign wr = req.strobe && look.changed;

	// On a strobed change, every matching slot takes the new pressed state and the edge time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				edge_q[i] <= '0;
			end
		end else if (wr) begin
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				if (match[i]) begin
					held_q[i] <= req.down;
					edge_q[i] <= req.stamp;
				end
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/button_press_duration_classifier.sv
`default_nettype none

// Channel   Dir  Handshake                      Word
// s_axis    in   s_axis_tvalid / s_axis_tready  pin, level, stamp
// m_axis    out  m_axis_tvalid / m_axis_tready  event_pin, event_time, event_code
// cfg       in   cfg_valid / cfg_ready          cfg_index, cfg_data
//
// One edge word is taken per cycle unless a stalled result holds the input register; a
// word passes the input register, then its result is loaded into the result register.
// Each word is matched against all slots, and the held time is formed by one 64-bit
// subtract and two signed compares in the cycle between the two registers.
// Reset sets the limits to 500000 and 4000000 us, marks all slots unused and no
// button held. cfg_ready is always high.
// While m_axis_tready is low a waiting result holds, and the word in the input
// register waits behind it whether or not that word gives a result; an empty input
// register still takes one more word.
module button_press_duration_classifier #(
	parameter int NUM_BUTTONS = 4
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// pin [5:0], level [6], stamp [69:7], zero [71:70]
	input  wire logic [bpdc_pkg::S_TDATA_W-1:0]   s_axis_tdata,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// event_pin [5:0], event_time [68:6], event_code [70:69], zero [71]
	output logic [bpdc_pkg::M_TDATA_W-1:0]        m_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [bpdc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [bpdc_pkg::CFG_DAT_W-1:0]   cfg_data
);
	import bpdc_pkg::*;

	logic [LIMIT_W-1:0]                  short_limit_q;
	logic [LIMIT_W-1:0]                  long_limit_q;
	logic [NUM_BUTTONS-1:0][PIN_W-1:0]   slot_pin_q;

	logic                                valid_s1;
	logic [PIN_W-1:0]                    pin_s1;
	logic                                level_s1;
	logic [STAMP_W-1:0]                  stamp_s1;

	logic                                out_valid_q;
	logic [PIN_W-1:0]                    out_pin_q;
	logic [STAMP_W-1:0]                  out_time_q;
	event_code_t                         out_code_q;

	logic                                process;
	logic                                pin_zero;
	logic                                has_result;
	logic signed [HELD_W-1:0]            held_time;
	event_code_t                         rel_code;
	slot_req_t                           req;
	slot_look_t                          look;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_limit_q <= SHORT_LIMIT_RST;
			long_limit_q  <= LONG_LIMIT_RST;
			slot_pin_q    <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SHORT_LIMIT: short_limit_q <= cfg_data;
				REG_LONG_LIMIT:  long_limit_q  <= cfg_data;
				default: begin
					for (int i = 0; i < NUM_BUTTONS; i++) begin
						if (i < SLOT_REGS && cfg_index == CFG_IDX_W'(REG_SLOT0_PIN + i)) begin
							slot_pin_q[i] <= cfg_data[PIN_W-1:0];
						end
					end
				end
			endcase
		end
	end

	// The word in the input register moves on unless a result is stuck.
	assign process       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || process;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			pin_s1   <= s_axis_tdata[PIN_W-1:0];
			level_s1 <= s_axis_tdata[PIN_W];
			stamp_s1 <= s_axis_tdata[PIN_W+STAMP_W:PIN_W+1];
		end
	end

	// Slot lookup and update; pin zero never touches the slots.
	assign pin_zero   = (pin_s1 == '0);
	assign req.strobe = process && !pin_zero;
	assign req.pin    = pin_s1;
	assign req.down   = !level_s1;
	assign req.stamp  = stamp_s1;

	bpdc_slots #(
		.NUM_BUTTONS(NUM_BUTTONS)
	) u_slots (
		.clk      (clk),
		.arst_n   (arst_n),
		.slot_pins(slot_pin_q),
		.req      (req),
		.look     (look)
	);

	// Held time is signed: an earlier stamp gives a negative time, a short release.
	assign held_time = signed'({1'b0, stamp_s1}) - signed'({1'b0, look.edge_time});

	always_comb begin
		if (held_time < signed'({{(HELD_W-LIMIT_W){1'b0}}, short_limit_q})) begin
			rel_code = EV_RELEASED;
		end else if (held_time < signed'({{(HELD_W-LIMIT_W){1'b0}}, long_limit_q})) begin
			rel_code = EV_LONG_RELEASED;
		end else begin
			rel_code = EV_VLONG_RELEASED;
		end
	end

	assign has_result = pin_zero || (look.changed && level_s1);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (process) begin
			out_valid_q <= has_result;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (process && has_result) begin
			out_pin_q  <= pin_s1;
			out_time_q <= stamp_s1;
			out_code_q <= pin_zero ? EV_PRESSED : rel_code;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_code_q, out_time_q, out_pin_q};

	// A pressed report always belongs to pin zero, a release never does.
	a_pressed_pin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((out_code_q == EV_PRESSED) == (out_pin_q == '0)))
		else $error("event code and pin disagree");

	// A word waiting behind a stalled result is kept intact.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !process) |=> (valid_s1 && $stable(pin_s1) && $stable(stamp_s1)))
		else $error("input register lost a waiting word");

	// A stalled result is not replaced.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(out_time_q)))
		else $error("result register changed while stalled");

	// A release is only reported for a slot that was held and now changes.
	a_release_src: assert property (@(posedge clk) disable iff (!arst_n)
		(process && has_result && !pin_zero) |-> (look.hit && look.held && level_s1))
		else $error("release without a held slot");

endmodule

`default_nettype wire
